/* sv/smog_pkg.sv */
package smog_pkg;

  localparam int unsigned DataW = 24;
  localparam int unsigned LimW  = 23;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegFilterEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxDepth     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxDelta     = 2'd2;

  localparam logic [LimW-1:0] MaxDepthReset = 23'd4000000;
  localparam logic [LimW-1:0] MaxDeltaReset = 23'd2000;

  localparam logic [1:0] VerdictAccept  = 2'd0;
  localparam logic [1:0] VerdictRange   = 2'd1;
  localparam logic [1:0] VerdictFilling = 2'd2;
  localparam logic [1:0] VerdictOutlier = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RANK,
    ST_PICK,
    ST_DONE
  } smog_state_e;

  // Control shared by every cell of the window chain.
  typedef struct packed {
    logic shift;  // push a new sample in, reload the rotating copy, clear ranks
    logic step;   // rotate the copy by one cell and update ranks
  } smog_ctrl_t;

endpackage

/* sv/smog_cell.sv */
module smog_cell #(
  parameter int unsigned RankW = 4,
  parameter int unsigned Index = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  smog_pkg::smog_ctrl_t                ctrl_i,
  input  logic [RankW-1:0]                    step_i,
  input  logic signed [smog_pkg::DataW-1:0]   shift_in_i,
  input  logic signed [smog_pkg::DataW-1:0]   rot_in_i,
  output logic signed [smog_pkg::DataW-1:0]   value_o,
  output logic signed [smog_pkg::DataW-1:0]   rot_o,
  output logic [RankW-1:0]                    rank_o
);

  logic signed [smog_pkg::DataW-1:0] value_q, rot_q;
  logic [RankW-1:0] rank_q, rank_d;
  logic             below;

  // The passing sample ranks below this one if it is smaller, or equal and
  // taken from a cell nearer the head of the chain.
  always_comb begin
    below  = (rot_in_i < value_q) ||
             ((rot_in_i == value_q) && (step_i <= RankW'(Index)));
    rank_d = rank_q;
    if (ctrl_i.shift) begin
      rank_d = '0;
    end else if (ctrl_i.step && below) begin
      rank_d = rank_q + RankW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      value_q <= shift_in_i;
      rot_q   <= shift_in_i;
    end else if (ctrl_i.step) begin
      rot_q <= rot_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= '0;
    end else begin
      rank_q <= rank_d;
    end
  end

  assign value_o = value_q;
  assign rot_o   = rot_q;
  assign rank_o  = rank_q;

endmodule

/* sv/sliding_median_outlier_gate.sv */
// Depth sample gate with a running median check. Every word on the input
// channel yields exactly one word on the output channel, in order. A sample
// whose magnitude is not below max_depth comes back as out of range; with
// the filter disabled every other sample is accepted and the history is left
// alone. With the filter enabled the sample is pushed into a chain of WINDOW
// cells holding the most recent samples; until WINDOW samples have been
// pushed it comes back as window filling, and after that the median (element
// WINDOW/2 in ascending order, the upper median for an even window) is found
// by rotating a copy of the window once around the chain while each cell
// counts how many samples rank below its own. The sample is accepted when its
// distance from that median is below max_delta, otherwise it is an outlier.
// One word is handled at a time, and a sample checked against the median
// passes through the WINDOW - 1 steps of the rank rotation in the cell
// chain before its result is formed. A finished result may wait in the
// output register while the next word is accepted, but that word's check
// step waits until the output register is free. Configuration writes are
// always taken and should only be issued while the block is idle.
module sliding_median_outlier_gate #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [smog_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [smog_pkg::LimW-1:0]           cfg_data_i,
  // Sample channel.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [smog_pkg::DataW-1:0]   depth_sample_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                accepted_o,
  output logic [1:0]                          verdict_o,
  output logic signed [smog_pkg::DataW-1:0]   depth_out_o,
  output logic signed [smog_pkg::DataW-1:0]   median_out_o
);

  localparam int unsigned DW    = smog_pkg::DataW;
  localparam int unsigned RankW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FillW = $clog2(WINDOW + 1);
  localparam logic [RankW-1:0] MedRank  = RankW'(WINDOW / 2);
  localparam logic [RankW-1:0] LastStep = RankW'(WINDOW - 1);
  localparam logic [FillW-1:0] FillFull = FillW'(WINDOW);

  // Configuration registers.
  logic                      filter_en_q;
  logic [smog_pkg::LimW-1:0] max_depth_q, max_delta_q;

  // Control and bookkeeping.
  smog_pkg::smog_state_e state_q, state_d;
  logic [FillW-1:0]      fill_q, fill_d;
  logic [RankW-1:0]      step_q, step_d;
  smog_pkg::smog_ctrl_t  ctrl;

  // Working sample and median.
  logic signed [DW-1:0] sample_q;
  logic signed [DW-1:0] med_q, med_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           verdict_q, verdict_d;
  logic signed [DW-1:0] median_out_q, median_out_d;
  logic signed [DW-1:0] depth_out_q;
  logic                 out_load;

  // Cell chain.
  logic signed [DW-1:0] cell_value [WINDOW];
  logic signed [DW-1:0] cell_rot   [WINDOW];
  logic [RankW-1:0]     cell_rank  [WINDOW];
  logic [WINDOW-1:0]    med_hit;

  logic                 out_free;
  logic [DW-1:0]        sample_mag;
  logic                 out_of_range;
  logic signed [DW:0]   diff;
  logic [DW:0]          diff_mag;
  logic                 near_median;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == smog_pkg::ST_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;

  // Magnitude in 24 bits unsigned: the most negative sample maps to 2^23,
  // which no 23-bit limit can exceed.
  assign sample_mag   = sample_q[DW-1] ? (~sample_q + DW'(1)) : sample_q;
  assign out_of_range = (sample_mag >= {1'b0, max_depth_q});

  assign diff        = {sample_q[DW-1], sample_q} - {med_q[DW-1], med_q};
  assign diff_mag    = diff[DW] ? (~diff + (DW+1)'(1)) : diff;
  assign near_median = (diff_mag < {2'b00, max_delta_q});

  generate
    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      localparam int unsigned Prev = (i + WINDOW - 1) % WINDOW;
      logic signed [DW-1:0] shift_in;

      if (i == 0) begin : g_head
        assign shift_in = sample_q;
      end else begin : g_body
        assign shift_in = cell_value[i-1];
      end

      smog_cell #(
        .RankW (RankW),
        .Index (i)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl),
        .step_i     (step_q),
        .shift_in_i (shift_in),
        .rot_in_i   (cell_rot[Prev]),
        .value_o    (cell_value[i]),
        .rot_o      (cell_rot[i]),
        .rank_o     (cell_rank[i])
      );

      assign med_hit[i] = (cell_rank[i] == MedRank);
    end
  endgenerate

  // The ranks form a permutation, so exactly one cell holds the median rank.
  always_comb begin
    med_d = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (med_hit[i]) begin
        med_d = med_d | cell_value[i];
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    step_d       = step_q;
    ctrl         = '0;
    out_load     = 1'b0;
    verdict_d    = verdict_q;
    median_out_d = median_out_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    case (state_q)
      smog_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = smog_pkg::ST_CHECK;
        end
      end
      smog_pkg::ST_CHECK: begin
        if (out_free) begin
          if (out_of_range) begin
            out_load     = 1'b1;
            verdict_d    = smog_pkg::VerdictRange;
            median_out_d = '0;
            state_d      = smog_pkg::ST_IDLE;
          end else if (!filter_en_q) begin
            out_load     = 1'b1;
            verdict_d    = smog_pkg::VerdictAccept;
            median_out_d = '0;
            state_d      = smog_pkg::ST_IDLE;
          end else begin
            ctrl.shift = 1'b1;
            if (fill_q != FillFull) begin
              fill_d = fill_q + FillW'(1);
            end
            if (fill_d != FillFull) begin
              out_load     = 1'b1;
              verdict_d    = smog_pkg::VerdictFilling;
              median_out_d = '0;
              state_d      = smog_pkg::ST_IDLE;
            end else if (WINDOW > 1) begin
              step_d  = RankW'(1);
              state_d = smog_pkg::ST_RANK;
            end else begin
              state_d = smog_pkg::ST_PICK;
            end
          end
        end
      end
      smog_pkg::ST_RANK: begin
        ctrl.step = 1'b1;
        if (step_q == LastStep) begin
          state_d = smog_pkg::ST_PICK;
        end else begin
          step_d = step_q + RankW'(1);
        end
      end
      smog_pkg::ST_PICK: begin
        state_d = smog_pkg::ST_DONE;
      end
      smog_pkg::ST_DONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          verdict_d    = near_median ? smog_pkg::VerdictAccept : smog_pkg::VerdictOutlier;
          median_out_d = med_q;
          state_d      = smog_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = smog_pkg::ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smog_pkg::ST_IDLE;
      fill_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      filter_en_q <= 1'b1;
      max_depth_q <= smog_pkg::MaxDepthReset;
      max_delta_q <= smog_pkg::MaxDeltaReset;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          smog_pkg::RegFilterEnable: filter_en_q <= cfg_data_i[0];
          smog_pkg::RegMaxDepth:     max_depth_q <= cfg_data_i;
          smog_pkg::RegMaxDelta:     max_delta_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q <= depth_sample_i;
    end
    if (state_q == smog_pkg::ST_PICK) begin
      med_q <= med_d;
    end
    if (out_load) begin
      verdict_q    <= verdict_d;
      median_out_q <= median_out_d;
      depth_out_q  <= sample_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign verdict_o    = verdict_q;
  assign accepted_o   = (verdict_q == smog_pkg::VerdictAccept);
  assign depth_out_o  = depth_out_q;
  assign median_out_o = median_out_q;

  // An accepted word always enters the check step in the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == smog_pkg::ST_CHECK)
    else $error("accepted word not taken into the check step");

  // The fill count saturates at the window length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull)
    else $error("fill count beyond the window length");

  // After the rank rotation exactly one cell holds the median rank.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smog_pkg::ST_PICK |-> $onehot(med_hit))
    else $error("median rank not unique after rotation");

  // Out-of-range and window-filling words report a zero median.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == smog_pkg::VerdictRange ||
                    verdict_o == smog_pkg::VerdictFilling) |-> median_out_o == '0)
    else $error("median reported without a median decision");

endmodule

/* tb/tb_sliding_median_outlier_gate.sv */
`timescale 1ns / 100ps

module tb_sliding_median_outlier_gate;

  localparam int WIN = 10;
  // Beyond the last register, so a write here must change nothing.
  localparam logic [smog_pkg::CfgIdxW-1:0] RegBeyondList = 2'd3;
  localparam logic signed [smog_pkg::DataW-1:0] DepthMin = 24'sh800000;
  localparam logic signed [smog_pkg::DataW-1:0] DepthMax = 24'sh7FFFFF;
  localparam logic [smog_pkg::LimW-1:0] LimMax = 23'h7FFFFF;
  // Cycles to let pass once the last result word is in: a full median pass plus margin.
  localparam int SettleCycles = 2 * WIN + 8;

  // One expected result word.
  typedef struct {
    logic                              accepted;
    logic [1:0]                        verdict;
    logic signed [smog_pkg::DataW-1:0] depth;
    logic signed [smog_pkg::DataW-1:0] median;
  } gate_outcome_t;

  logic                              clk          = 1'b0;
  logic                              rst_n        = 1'b0;
  logic                              cfg_valid    = 1'b0;
  logic [smog_pkg::CfgIdxW-1:0]      cfg_index    = '0;
  logic [smog_pkg::LimW-1:0]         cfg_data     = '0;
  logic                              in_valid     = 1'b0;
  logic signed [smog_pkg::DataW-1:0] depth_sample = '0;
  logic                              out_ready    = 1'b0;
  logic                              cfg_ready;
  logic                              in_ready;
  logic                              out_valid;
  logic                              accepted;
  logic [1:0]                        verdict;
  logic signed [smog_pkg::DataW-1:0] depth_out;
  logic signed [smog_pkg::DataW-1:0] median_out;

  // Samples waiting to be offered, and result words that are owed by the block.
  logic signed [smog_pkg::DataW-1:0] samples_to_send [$];
  gate_outcome_t                     outcomes_due [$];

  // Our own copy of the configuration and of the sample history.
  bit                                filt_on   = 1'b1;
  logic [smog_pkg::LimW-1:0]         depth_lim = smog_pkg::MaxDepthReset;
  logic [smog_pkg::LimW-1:0]         delta_lim = smog_pkg::MaxDeltaReset;
  logic signed [smog_pkg::DataW-1:0] history [WIN];
  int                                hist_fill = 0;
  int                                hist_next = 0;

  bit idle_on = 1'b1;
  int in_gap  = 0;
  int out_gap = 0;
  int mismatch_count = 0;

  sliding_median_outlier_gate #(
    .WINDOW(WIN)
  ) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .depth_sample_i(depth_sample),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .accepted_o    (accepted),
    .verdict_o     (verdict),
    .depth_out_o   (depth_out),
    .median_out_o  (median_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // A random register value of the limit width.
  function automatic logic [smog_pkg::LimW-1:0] rand_lim();
    logic [31:0] r;
    r = $urandom;
    return r[smog_pkg::LimW-1:0];
  endfunction

  // Works out the result word for one accepted sample and advances the history. Out-of-range
  // samples and bypassed samples leave the history alone; filtered samples enter the window
  // and are judged against the upper median once the window has been filled.
  function automatic gate_outcome_t judge_depth(logic signed [smog_pkg::DataW-1:0] s);
    gate_outcome_t                     o;
    logic signed [smog_pkg::DataW-1:0] sorted [WIN];
    logic signed [smog_pkg::DataW-1:0] key;
    int                                v;
    int                                mag;
    int                                med;
    int                                d;
    int                                j;
    v   = int'(s);
    mag = (v < 0) ? -v : v;
    med = 0;
    if (mag >= int'(depth_lim)) begin
      o.verdict = smog_pkg::VerdictRange;
    end else if (!filt_on) begin
      o.verdict = smog_pkg::VerdictAccept;
    end else begin
      history[hist_next] = s;
      hist_next = (hist_next + 1 == WIN) ? 0 : hist_next + 1;
      if (hist_fill < WIN) hist_fill++;
      if (hist_fill < WIN) begin
        o.verdict = smog_pkg::VerdictFilling;
      end else begin
        sorted = history;
        for (int i = 1; i < WIN; i++) begin
          key = sorted[i];
          j = i - 1;
          while (j >= 0 && sorted[j] > key) begin
            sorted[j + 1] = sorted[j];
            j--;
          end
          sorted[j + 1] = key;
        end
        med = int'(sorted[WIN / 2]);
        d = v - med;
        if (d < 0) d = -d;
        o.verdict = (d < int'(delta_lim)) ? smog_pkg::VerdictAccept : smog_pkg::VerdictOutlier;
      end
    end
    o.accepted = (o.verdict == smog_pkg::VerdictAccept);
    o.depth    = s;
    o.median   = med[smog_pkg::DataW-1:0];
    return o;
  endfunction

  task automatic report_mismatch(string field, logic signed [31:0] got,
                                 logic signed [31:0] want);
    $display("%0t: mismatch on %s, got %0d, expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  // Sample driver. A new word is put up only once the previous one has been taken, and a
  // burst of idle cycles may be slipped in before any word while idling is allowed.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      depth_sample <= '0;
      in_gap       <= 0;
    end else begin
      if (in_valid && in_ready) begin
        outcomes_due.push_back(judge_depth(depth_sample));
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (samples_to_send.size() != 0) begin
          if (idle_on && $urandom_range(0, 5) == 0) begin
            in_gap   <= $urandom_range(0, 7);
            in_valid <= 1'b0;
          end else begin
            in_valid     <= 1'b1;
            depth_sample <= samples_to_send.pop_front();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every word taken is checked field by field against the oldest word owed;
  // the ready line is dropped in random bursts while idling is allowed.
  always @(posedge clk or negedge rst_n) begin : result_monitor
    gate_outcome_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (outcomes_due.size() == 0) begin
          report_mismatch("result word with none owed", 32'(depth_out), 0);
        end else begin
          want = outcomes_due.pop_front();
          if (accepted !== want.accepted)
            report_mismatch("accepted", 32'(accepted), 32'(want.accepted));
          if (verdict !== want.verdict)
            report_mismatch("verdict", 32'(verdict), 32'(want.verdict));
          if (depth_out !== want.depth)
            report_mismatch("depth_out", 32'(depth_out), 32'(want.depth));
          if (median_out !== want.median)
            report_mismatch("median_out", 32'(median_out), 32'(want.median));
        end
      end
      if (out_gap != 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_gap   <= $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Writes one register through the configuration channel and mirrors it in our copy.
  task automatic cfg_write(logic [smog_pkg::CfgIdxW-1:0] idx,
                           logic [smog_pkg::LimW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      smog_pkg::RegFilterEnable: filt_on   = data[0];
      smog_pkg::RegMaxDepth:     depth_lim = data;
      smog_pkg::RegMaxDelta:     delta_lim = data;
      default: ;
    endcase
  endtask

  // The enable word carries random upper bits, which the block must ignore.
  task automatic set_limits(bit filt, logic [smog_pkg::LimW-1:0] dlim,
                            logic [smog_pkg::LimW-1:0] elim);
    logic [smog_pkg::LimW-1:0] en_word;
    en_word = rand_lim();
    en_word[0] = filt;
    cfg_write(smog_pkg::RegFilterEnable, en_word);
    cfg_write(smog_pkg::RegMaxDepth, dlim);
    cfg_write(smog_pkg::RegMaxDelta, elim);
  endtask

  // Waits until every sample has been taken and every owed word has come back, then waits
  // out the settle margin before anything else is changed.
  task automatic settle();
    while (samples_to_send.size() != 0 || in_valid || outcomes_due.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic queue_sample(int v);
    if (v > int'(DepthMax)) v = int'(DepthMax);
    if (v < int'(DepthMin)) v = int'(DepthMin);
    samples_to_send.push_back(v[smog_pkg::DataW-1:0]);
  endtask

  // A track of depth readings: mostly a steady depth with noise around the current delta
  // limit, so that the window fills and the median check sees both verdicts, mixed with
  // jumps, full-range noise, the range limits and the odd change of the steady depth.
  task automatic queue_track(int n);
    int reach;
    int span;
    int base;
    int lim;
    int r;
    int v;
    lim   = int'(depth_lim);
    reach = (lim > 0) ? lim / 4 * 3 : 1000;
    span  = (delta_lim == 0) ? 64 : ((delta_lim > 100000) ? 100000 : int'(delta_lim));
    base  = int'($urandom_range(0, 2 * reach)) - reach;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        v = base + int'($urandom_range(0, 2 * span)) - span;
      end else if (r < 80) begin
        v = base + int'($urandom_range(span, 5 * span)) * ($urandom_range(0, 1) ? 1 : -1);
      end else if (r < 90) begin
        v = $signed(($urandom & 32'hFFFFFF) << 8) >>> 8;
      end else if (r < 95) begin
        case ($urandom_range(0, 5))
          0: v = int'(DepthMin);
          1: v = int'(DepthMax);
          2: v = lim;
          3: v = -lim;
          4: v = lim - 1;
          default: v = 1 - lim;
        endcase
      end else begin
        base = int'($urandom_range(0, 2 * reach)) - reach;
        v = base;
      end
      queue_sample(v);
    end
  endtask

  initial begin : stimulus
    logic [smog_pkg::LimW-1:0] dlim;
    logic [smog_pkg::LimW-1:0] elim;
    bit                        filt;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset limits first: the most negative sample and the depth bounds.
    queue_sample(int'(DepthMin));
    queue_sample(int'(DepthMax));
    queue_sample(4000000);
    queue_sample(-4000000);
    // Fill the window; the tenth sample is the first judged against the median.
    queue_sample(3999999);
    queue_sample(-3999999);
    queue_sample(100);
    queue_sample(200);
    queue_sample(150);
    queue_sample(120);
    queue_sample(180);
    queue_sample(160);
    queue_sample(140);
    queue_sample(130);
    queue_sample(2150);
    queue_sample(20000);
    settle();

    // Bypass keeps the history; filtering then resumes on what was kept.
    set_limits(1'b0, smog_pkg::MaxDepthReset, smog_pkg::MaxDeltaReset);
    queue_sample(5);
    queue_sample(-7);
    queue_sample(int'(DepthMin));
    settle();
    cfg_write(smog_pkg::RegFilterEnable, 23'd1);
    queue_sample(140);
    settle();

    // Zero depth limit rejects everything, zero delta makes every filtered sample an outlier.
    set_limits(1'b1, '0, smog_pkg::MaxDeltaReset);
    queue_sample(0);
    settle();
    set_limits(1'b1, smog_pkg::MaxDepthReset, '0);
    queue_sample(150);
    settle();

    // Widest limits, and a write past the last register that must leave them alone.
    set_limits(1'b1, LimMax, LimMax);
    cfg_write(RegBeyondList, rand_lim());
    queue_sample(int'(DepthMax));
    queue_sample(8388606);
    queue_sample(-8388607);
    queue_sample(0);
    settle();

    // Random phases, each with its own setting; the last two run without any idling.
    for (int p = 0; p < 12; p++) begin
      filt = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 11))
        0:       dlim = '0;
        1, 2:    dlim = LimMax;
        3, 4:    dlim = smog_pkg::MaxDepthReset;
        default: dlim = rand_lim();
      endcase
      case ($urandom_range(0, 9))
        0:       elim = '0;
        1:       elim = LimMax;
        2, 3:    elim = smog_pkg::MaxDeltaReset;
        4, 5:    elim = rand_lim();
        default: elim = smog_pkg::LimW'($urandom_range(1, 65535));
      endcase
      set_limits(filt, dlim, elim);
      if ($urandom_range(0, 3) == 0) cfg_write(RegBeyondList, rand_lim());
      idle_on = (p < 10) ? ($urandom_range(0, 3) != 0) : 1'b0;
      queue_track(150);
      settle();
    end

    if (mismatch_count == 0) begin
      $display("[sliding_median_outlier_gate] OK");
    end else begin
      $display("[sliding_median_outlier_gate] ERROR");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every word through a full median pass with the
  // longest gaps on both sides.
  initial begin : watchdog
    #4000000;
    $display("[sliding_median_outlier_gate] ERROR");
    $finish;
  end

endmodule

/* sim.f */
sv/smog_pkg.sv
sv/smog_cell.sv
sv/sliding_median_outlier_gate.sv
tb/tb_sliding_median_outlier_gate.sv
